// File: src/rnsh_pkg.sv
// Shared types, constants and helper functions of the ray nearest sphere hit unit.
package rnsh_pkg;

    localparam int MAX_SPHERES = 64;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(MAX_SPHERES);
    localparam int CNT_W       = 7;
    localparam int ACC_W       = 50;
    localparam int SQ_ITERS    = 32;
    localparam int SQ_CNT_W    = $clog2(SQ_ITERS);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    // outcome codes
    localparam logic [1:0] OUT_SKIP = 2'd0;
    localparam logic [1:0] OUT_HIT  = 2'd1;
    localparam logic [1:0] OUT_EXIT = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic signed [7:0] OWNER_EXITED = -8'sd1;

    typedef struct packed {
        logic               mode;
        logic [5:0]         entry_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        sphere_radius;
        logic signed [7:0]  ray_owner;
        logic signed [31:0] prior_distance;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [7:0]  new_owner;
        logic signed [31:0] hit_distance;
    } result_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        radius;
    } sphere_t;

    typedef enum logic [1:0] {
        K_LOAD,
        K_SKIP,
        K_TEST
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } qentry_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ,
        B_OC,
        B_MUL,
        B_PSAT,
        B_PP,
        B_DISC,
        B_SQRT,
        B_DIST
    } back_state_t;

    // saturate an accumulator value to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(signed'(32'h7fffffff)))
            r = 32'sh7fffffff;
        else if (v < ACC_W'(signed'(32'h80000000)))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturate a 33 bit difference to 32 bits signed
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: src/rnsh_ram.sv
// Generic single write, single read RAM with registered read data.
module rnsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/rnsh_queue.sv
// Short item queue between the front classifier and the back engine.
module rnsh_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rnsh_pkg::qentry_t push_data,
    input  logic              pop,
    output rnsh_pkg::qentry_t head,
    output logic              full,
    output logic              empty
);

    rnsh_pkg::qentry_t              slots_reg [rnsh_pkg::QDEPTH];
    logic [rnsh_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rnsh_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rnsh_pkg::QPTR_W:0]      fill_reg;

    assign full  = (fill_reg == (rnsh_pkg::QPTR_W + 1)'(rnsh_pkg::QDEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/rnsh_front.sv
// Front part: sphere count register, item acceptance and classification.
module rnsh_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  rnsh_pkg::in_item_t          item,
    input  logic                        cfg_we,
    input  logic [rnsh_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                        q_full,
    output logic                        busy,
    output logic                        q_push,
    output rnsh_pkg::qentry_t           q_data,
    output logic [rnsh_pkg::CNT_W-1:0]  active_count
);

    logic [rnsh_pkg::CNT_W-1:0] count_reg;
    logic                       skip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // clamp to the table size
    assign active_count = (count_reg > rnsh_pkg::CNT_W'(rnsh_pkg::MAX_SPHERES))
                        ? rnsh_pkg::CNT_W'(rnsh_pkg::MAX_SPHERES) : count_reg;

    // exited rays and rays inside an in-use sphere pass through
    assign skip = (item.ray_owner == rnsh_pkg::OWNER_EXITED)
               || (!item.ray_owner[7] && (item.ray_owner[6:0] < active_count));

    assign busy   = q_full;
    assign q_push = start && !q_full;

    always_comb
    begin
        q_data.item = item;
        if (item.mode == rnsh_pkg::MODE_LOAD)
            q_data.kind = rnsh_pkg::K_LOAD;
        else if (skip)
            q_data.kind = rnsh_pkg::K_SKIP;
        else
            q_data.kind = rnsh_pkg::K_TEST;
    end

endmodule

// File: src/rnsh_back.sv
// Back part: table writes, per-sphere intersection sequencer and nearest hit choice.
module rnsh_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rnsh_pkg::qentry_t           q_head,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic [rnsh_pkg::CNT_W-1:0]  active_count,
    output logic                        done,
    output rnsh_pkg::result_t           result
);

    localparam int SW = $bits(rnsh_pkg::sphere_t);

    rnsh_pkg::back_state_t          state_reg, state_next;
    rnsh_pkg::in_item_t             cur_reg, cur_next;
    logic [rnsh_pkg::CNT_W-1:0]     j_reg, j_next;
    logic [2:0]                     k_reg, k_next;
    logic signed [31:0]             oc_reg [3];
    logic signed [31:0]             oc_next [3];
    logic [30:0]                    r_reg, r_next;
    logic signed [63:0]             prod_reg, prod_next;
    logic signed [rnsh_pkg::ACC_W-1:0] ocsq_reg, ocsq_next;
    logic signed [rnsh_pkg::ACC_W-1:0] p_reg, p_next;
    logic signed [rnsh_pkg::ACC_W-1:0] rr_reg, rr_next;
    logic signed [31:0]             psat_reg, psat_next;
    logic [63:0]                    n_reg, n_next;
    logic [63:0]                    root_reg, root_next;
    logic [63:0]                    bit_reg, bit_next;
    logic [rnsh_pkg::SQ_CNT_W-1:0]  sq_cnt_reg, sq_cnt_next;
    logic                           found_reg, found_next;
    logic signed [31:0]             best_d_reg, best_d_next;
    logic [rnsh_pkg::IDX_W-1:0]     best_j_reg, best_j_next;
    logic                           done_reg, done_next;
    rnsh_pkg::result_t              result_reg, result_next;

    logic                           ram_we;
    rnsh_pkg::sphere_t              ram_wdata;
    logic [SW-1:0]                  ram_rdata;
    rnsh_pkg::sphere_t              sph;
    logic signed [32:0]             mul_a, mul_b;
    logic signed [65:0]             mul_p;
    logic signed [63:0]             prod_sh;
    logic signed [rnsh_pkg::ACC_W-1:0] sh;
    logic signed [rnsh_pkg::ACC_W-1:0] disc;
    logic signed [rnsh_pkg::ACC_W-1:0] dist_w;
    logic signed [31:0]             dist_sat;
    logic [63:0]                    trial;
    logic                           advance;
    logic                           last;

    assign ram_wdata.cx     = q_head.item.pos_x;
    assign ram_wdata.cy     = q_head.item.pos_y;
    assign ram_wdata.cz     = q_head.item.pos_z;
    assign ram_wdata.radius = q_head.item.sphere_radius;

    rnsh_ram #(
        .WIDTH (SW),
        .DEPTH (rnsh_pkg::MAX_SPHERES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rnsh_pkg::IDX_W'(q_head.item.entry_index)),
        .wdata (ram_wdata),
        .raddr (j_reg[rnsh_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign sph = rnsh_pkg::sphere_t'(ram_rdata);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == rnsh_pkg::B_PP)
        begin
            mul_a = 33'(psat_reg);
            mul_b = 33'(psat_reg);
        end
        else
        begin
            case (k_reg)
                3'd0:    begin mul_a = 33'(oc_reg[0]);     mul_b = 33'(oc_reg[0]); end
                3'd1:    begin mul_a = 33'(oc_reg[1]);     mul_b = 33'(oc_reg[1]); end
                3'd2:    begin mul_a = 33'(oc_reg[2]);     mul_b = 33'(oc_reg[2]); end
                3'd3:    begin mul_a = 33'(cur_reg.dir_x); mul_b = 33'(oc_reg[0]); end
                3'd4:    begin mul_a = 33'(cur_reg.dir_y); mul_b = 33'(oc_reg[1]); end
                3'd5:    begin mul_a = 33'(cur_reg.dir_z); mul_b = 33'(oc_reg[2]); end
                3'd6:    begin mul_a = signed'({2'b00, r_reg}); mul_b = signed'({2'b00, r_reg}); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_sh  = prod_reg >>> rnsh_pkg::FRAC_BITS;
    assign sh       = signed'(prod_sh[rnsh_pkg::ACC_W-1:0]);
    assign disc     = sh + rr_reg - ocsq_reg;
    assign trial    = root_reg + bit_reg;
    assign dist_w   = -rnsh_pkg::ACC_W'(psat_reg)
                    - signed'({1'b0, root_reg[rnsh_pkg::ACC_W-2:0]});
    assign dist_sat = rnsh_pkg::sat32(dist_w);
    assign last     = (j_reg + 1'b1) >= active_count;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        oc_next     = oc_reg;
        r_next      = r_reg;
        prod_next   = prod_reg;
        ocsq_next   = ocsq_reg;
        p_next      = p_reg;
        rr_next     = rr_reg;
        psat_next   = psat_reg;
        n_next      = n_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        sq_cnt_next = sq_cnt_reg;
        found_next  = found_reg;
        best_d_next = best_d_reg;
        best_j_next = best_j_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        advance     = 1'b0;

        case (state_reg)
            rnsh_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        rnsh_pkg::K_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        rnsh_pkg::K_SKIP:
                        begin
                            done_next                = 1'b1;
                            result_next.outcome      = rnsh_pkg::OUT_SKIP;
                            result_next.new_owner    = q_head.item.ray_owner;
                            result_next.hit_distance = q_head.item.prior_distance;
                        end
                        default:
                        begin
                            cur_next   = q_head.item;
                            j_next     = '0;
                            found_next = 1'b0;
                            if (active_count == '0)
                            begin
                                done_next                = 1'b1;
                                result_next.outcome      = rnsh_pkg::OUT_EXIT;
                                result_next.new_owner    = rnsh_pkg::OWNER_EXITED;
                                result_next.hit_distance = q_head.item.prior_distance;
                            end
                            else
                            begin
                                state_next = rnsh_pkg::B_READ;
                            end
                        end
                    endcase
                end
            end
            rnsh_pkg::B_READ:
            begin
                state_next = rnsh_pkg::B_OC;
            end
            rnsh_pkg::B_OC:
            begin
                oc_next[0] = rnsh_pkg::sat33(33'(cur_reg.pos_x) - 33'(sph.cx));
                oc_next[1] = rnsh_pkg::sat33(33'(cur_reg.pos_y) - 33'(sph.cy));
                oc_next[2] = rnsh_pkg::sat33(33'(cur_reg.pos_z) - 33'(sph.cz));
                r_next     = sph.radius;
                ocsq_next  = '0;
                p_next     = '0;
                k_next     = '0;
                state_next = rnsh_pkg::B_MUL;
            end
            rnsh_pkg::B_MUL:
            begin
                // product of step k, accumulate product of step k-1
                prod_next = mul_p[63:0];
                case (k_reg)
                    3'd1, 3'd2, 3'd3: ocsq_next = ocsq_reg + sh;
                    3'd4, 3'd5, 3'd6: p_next    = p_reg + sh;
                    3'd7:             rr_next   = sh;
                    default:          ;
                endcase
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd7)
                begin
                    state_next = rnsh_pkg::B_PSAT;
                end
            end
            rnsh_pkg::B_PSAT:
            begin
                psat_next  = rnsh_pkg::sat32(p_reg);
                state_next = rnsh_pkg::B_PP;
            end
            rnsh_pkg::B_PP:
            begin
                prod_next  = mul_p[63:0];
                state_next = rnsh_pkg::B_DISC;
            end
            rnsh_pkg::B_DISC:
            begin
                if (disc <= 0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    n_next      = 64'(disc) << rnsh_pkg::FRAC_BITS;
                    root_next   = '0;
                    bit_next    = 64'd1 << 62;
                    sq_cnt_next = '0;
                    state_next  = rnsh_pkg::B_SQRT;
                end
            end
            rnsh_pkg::B_SQRT:
            begin
                // one result bit per cycle
                if (n_reg >= trial)
                begin
                    n_next    = n_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next    = bit_reg >> 2;
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == rnsh_pkg::SQ_CNT_W'(rnsh_pkg::SQ_ITERS - 1))
                begin
                    state_next = rnsh_pkg::B_DIST;
                end
            end
            rnsh_pkg::B_DIST:
            begin
                if ((dist_sat > cur_reg.prior_distance) && (dist_sat >= 0)
                    && (!found_reg || (dist_sat < best_d_reg)))
                begin
                    found_next  = 1'b1;
                    best_d_next = dist_sat;
                    best_j_next = j_reg[rnsh_pkg::IDX_W-1:0];
                end
                advance = 1'b1;
            end
            default:
            begin
                state_next = rnsh_pkg::B_IDLE;
            end
        endcase

        // next sphere or final answer
        if (advance)
        begin
            if (last)
            begin
                state_next = rnsh_pkg::B_IDLE;
                done_next  = 1'b1;
                if (found_next)
                begin
                    result_next.outcome      = rnsh_pkg::OUT_HIT;
                    result_next.new_owner    = signed'(8'(best_j_next));
                    result_next.hit_distance = best_d_next;
                end
                else
                begin
                    result_next.outcome      = rnsh_pkg::OUT_EXIT;
                    result_next.new_owner    = rnsh_pkg::OWNER_EXITED;
                    result_next.hit_distance = cur_reg.prior_distance;
                end
            end
            else
            begin
                j_next     = j_reg + 1'b1;
                state_next = rnsh_pkg::B_READ;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rnsh_pkg::B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        oc_reg     <= oc_next;
        r_reg      <= r_next;
        prod_reg   <= prod_next;
        ocsq_reg   <= ocsq_next;
        p_reg      <= p_next;
        rr_reg     <= rr_next;
        psat_reg   <= psat_next;
        n_reg      <= n_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        sq_cnt_reg <= sq_cnt_next;
        found_reg  <= found_next;
        best_d_reg <= best_d_next;
        best_j_reg <= best_j_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_exit_owner: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.outcome == rnsh_pkg::OUT_EXIT)
        |-> result.new_owner == rnsh_pkg::OWNER_EXITED)
        else $error("exit result without exited owner");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.outcome == rnsh_pkg::OUT_HIT)
        |-> (result.hit_distance >= 0) && !result.new_owner[7])
        else $error("hit result with negative distance or owner");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rnsh_pkg::B_IDLE) |-> !q_pop && !ram_we)
        else $error("queue popped while a ray is in work");

    a_sqrt_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rnsh_pkg::B_SQRT) && ($past(state_reg) != rnsh_pkg::B_SQRT)
        |-> $past(state_reg) == rnsh_pkg::B_DISC)
        else $error("root iteration entered out of order");

endmodule

// File: src/ray_nearest_sphere_hit_unit.sv
// Top level of the ray nearest sphere hit unit.
// Usage:
//   Items enter on start/item and are taken at a clock edge where start is
//   high and busy is low. busy rises only when the two-entry queue is full.
//   A load item (mode 0) writes one table slot; a ray item (mode 1) yields
//   exactly one result on result, marked by a one-cycle done strobe that the
//   receiver must take in that cycle.
//   cfg_we/cfg_wdata write sphere_count; write it only while the unit is idle.
// Flow:
//   A load item or a skipped ray is handled as it leaves the queue; a
//   skipped ray's result and done strobe are registered.
//   A tested ray runs, per in-use sphere, table read, offset, the multiply
//   steps on the single shared multiplier and the discriminant test, and
//   the 32-step integer square root only when the discriminant is positive.
//   Items queue behind a ray in work and are handled strictly in order.
// Reset:
//   rst_n clears the queue, the sequencer and sphere_count; the sphere table
//   holds nothing meaningful until its slots are loaded.
module ray_nearest_sphere_hit_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rnsh_pkg::in_item_t          item,
    input  logic                        cfg_we,
    input  logic [rnsh_pkg::CNT_W-1:0]  cfg_wdata,
    output logic                        done,
    output rnsh_pkg::result_t           result
);

    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    rnsh_pkg::qentry_t          q_data;
    rnsh_pkg::qentry_t          q_head;
    logic [rnsh_pkg::CNT_W-1:0] active_count;

    rnsh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .busy         (busy),
        .q_push       (q_push),
        .q_data       (q_data),
        .active_count (active_count)
    );

    rnsh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rnsh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .active_count (active_count),
        .done         (done),
        .result       (result)
    );

endmodule
